[rtl/pss_pkg.sv]
package pss_pkg;

    localparam int DEPTH = 32;
    // count must hold DEPTH itself
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int POS_W = 6;
    localparam int LEN_W = 6;
    // compare width covers both the count and the position field
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int VAL_W = 32;

    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 40;

    typedef enum logic [2:0] {
        ACT_INS_FRONT = 3'd0,
        ACT_INS_END   = 3'd1,
        ACT_INS_POS   = 3'd2,
        ACT_DEL_FRONT = 3'd3,
        ACT_DEL_END   = 3'd4,
        ACT_DEL_POS   = 3'd5,
        ACT_LIST      = 3'd6
    } action_t;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    typedef enum logic [1:0] {
        OP_HOLD = 2'd0,
        OP_INS  = 2'd1,
        OP_DEL  = 2'd2,
        OP_ROT  = 2'd3
    } cell_op_t;

    typedef struct packed {
        cell_op_t           op;
        logic [CMP_W-1:0]   slot;
        logic [CMP_W-1:0]   count;
        logic [VAL_W-1:0]   value;
    } cell_ctrl_t;

    function automatic logic [LEN_W-1:0] len_field(input logic [CNT_W-1:0] cnt);
        logic [CMP_W-1:0] wide;
        wide = CMP_W'(cnt);
        return wide[LEN_W-1:0];
    endfunction

endpackage

[rtl/pss_cell.sv]
module pss_cell (
    input  logic                        clk,
    input  pss_pkg::cell_ctrl_t         ctrl,
    input  logic [pss_pkg::CMP_W-1:0]   idx,
    input  logic [pss_pkg::VAL_W-1:0]   left_data,
    input  logic [pss_pkg::VAL_W-1:0]   right_data,
    input  logic [pss_pkg::VAL_W-1:0]   first_data,
    output logic [pss_pkg::VAL_W-1:0]   data
);
    import pss_pkg::*;

    logic [VAL_W-1:0] data_reg;
    logic [VAL_W-1:0] data_next;
    logic [CMP_W-1:0] idx_p1;

    assign idx_p1 = idx + CMP_W'(1);

    always_comb
    begin
        data_next = data_reg;
        case (ctrl.op)
            OP_INS:
            begin
                if (idx > ctrl.slot)
                    data_next = left_data;
                else if (idx == ctrl.slot)
                    data_next = ctrl.value;
            end
            OP_DEL:
            begin
                if (idx >= ctrl.slot)
                    data_next = right_data;
            end
            OP_ROT:
            begin
                // rotate only the occupied cells, tail takes the front
                if (idx_p1 == ctrl.count)
                    data_next = first_data;
                else if (idx_p1 < ctrl.count)
                    data_next = right_data;
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

[rtl/positional_sequence_store_unit.sv]
// positional sequence store
// holds an ordered sequence of up to DEPTH signed 32-bit values in a row of
// shifting cells, front in cell 0.
// input channel s_*: one transaction per action; s_tdata carries action,
// value and position. output channel m_*: m_tdata carries status, element
// and length after the action; m_tuser is has_element, m_tlast marks the
// final result of an action.
// insert and delete move cells from the slot on at once on acceptance; the
// status result is shown in the next cycle, and with a ready receiver a new
// action is taken every cycle.
// list rotates the occupied cells one place per cycle while the output is
// free, emitting the front cell each time; acceptance enters the list state,
// each rotation loads the output register, the next action waits for the
// list state to end, and an empty list gives a single empty-status result.
// one action at a time: s_tready is high only while no list is running and
// the output register is empty or being taken.
// a stalled receiver holds the output register and the cell row; nothing
// is lost or reordered.
// reset clears the count, the control state and the output valid; cell
// contents are left as they are.
module positional_sequence_store_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // action[2:0], value[34:3], position[40:35], zero pad
    input  logic [pss_pkg::IN_DATA_W-1:0]       s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // status[1:0], element[33:2], length_now[39:34]
    output logic [pss_pkg::OUT_DATA_W-1:0]      m_tdata,
    // has_element
    output logic                                m_tuser,
    output logic                                m_tlast
);
    import pss_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_LIST = 2'b10
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  remain_reg, remain_next;

    logic              out_valid_reg, out_valid_next;
    logic [1:0]        out_status_reg, out_status_next;
    logic [VAL_W-1:0]  out_elem_reg, out_elem_next;
    logic              out_has_reg, out_has_next;
    logic              out_last_reg, out_last_next;
    logic [LEN_W-1:0]  out_len_reg, out_len_next;

    cell_ctrl_t        ctrl;
    logic [VAL_W-1:0]  cell_data [DEPTH];
    logic [VAL_W-1:0]  left_w    [DEPTH];
    logic [VAL_W-1:0]  right_w   [DEPTH];

    action_t           act;
    logic [VAL_W-1:0]  in_value;
    logic [POS_W-1:0]  in_pos;
    logic [CMP_W-1:0]  pos_x;
    logic [CMP_W-1:0]  count_x;
    logic              full;
    logic              empty;
    logic              accept;
    logic              out_free;

    assign act      = action_t'(s_tdata[2:0]);
    assign in_value = s_tdata[34:3];
    assign in_pos   = s_tdata[40:35];
    assign pos_x    = CMP_W'(in_pos);
    assign count_x  = CMP_W'(count_reg);
    assign full     = (count_x >= CMP_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE) && out_free;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        remain_next     = remain_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_status_next = out_status_reg;
        out_elem_next   = out_elem_reg;
        out_has_next    = out_has_reg;
        out_last_next   = out_last_reg;
        out_len_next    = out_len_reg;

        ctrl.op    = OP_HOLD;
        ctrl.slot  = '0;
        ctrl.count = count_x;
        ctrl.value = in_value;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    out_status_next = ST_OK;
                    out_elem_next   = '0;
                    out_has_next    = 1'b0;
                    out_last_next   = 1'b1;
                    out_valid_next  = 1'b1;
                    case (act)
                        ACT_INS_FRONT, ACT_INS_END, ACT_INS_POS:
                        begin
                            if (full)
                                out_status_next = ST_FULL;
                            else if (act == ACT_INS_POS && pos_x > count_x)
                                out_status_next = ST_RANGE;
                            else
                            begin
                                ctrl.op = OP_INS;
                                if (act == ACT_INS_END)
                                    ctrl.slot = count_x;
                                else if (act == ACT_INS_POS)
                                    ctrl.slot = pos_x;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        ACT_DEL_FRONT, ACT_DEL_END, ACT_DEL_POS:
                        begin
                            if (empty)
                                out_status_next = ST_EMPTY;
                            else if (act == ACT_DEL_POS &&
                                     (pos_x == '0 || pos_x > count_x))
                                out_status_next = ST_RANGE;
                            else
                            begin
                                ctrl.op = OP_DEL;
                                if (act == ACT_DEL_END)
                                    ctrl.slot = count_x - CMP_W'(1);
                                else if (act == ACT_DEL_POS)
                                    ctrl.slot = pos_x - CMP_W'(1);
                                count_next = count_reg - CNT_W'(1);
                            end
                        end
                        ACT_LIST:
                        begin
                            if (empty)
                                out_status_next = ST_EMPTY;
                            else
                            begin
                                out_valid_next = 1'b0;
                                remain_next    = count_reg;
                                state_next     = S_LIST;
                            end
                        end
                        default:
                        begin
                            out_status_next = ST_OK;
                        end
                    endcase
                    out_len_next = len_field(count_next);
                end
            end
            S_LIST:
            begin
                if (out_free)
                begin
                    ctrl.op         = OP_ROT;
                    out_valid_next  = 1'b1;
                    out_status_next = ST_OK;
                    out_elem_next   = cell_data[0];
                    out_has_next    = 1'b1;
                    out_last_next   = (remain_reg == CNT_W'(1));
                    out_len_next    = len_field(count_reg);
                    remain_next     = remain_reg - CNT_W'(1);
                    if (remain_reg == CNT_W'(1))
                        state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            remain_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            remain_reg    <= remain_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_status_reg <= out_status_next;
        out_elem_reg   <= out_elem_next;
        out_has_reg    <= out_has_next;
        out_last_reg   <= out_last_next;
        out_len_reg    <= out_len_next;
    end

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            if (i == 0)
            begin : g_head
                assign left_w[i] = cell_data[i];
            end
            else
            begin : g_left
                assign left_w[i] = cell_data[i-1];
            end
            if (i == DEPTH - 1)
            begin : g_tail
                assign right_w[i] = cell_data[i];
            end
            else
            begin : g_right
                assign right_w[i] = cell_data[i+1];
            end

            pss_cell u_cell (
                .clk        (clk),
                .ctrl       (ctrl),
                .idx        (CMP_W'(i)),
                .left_data  (left_w[i]),
                .right_data (right_w[i]),
                .first_data (cell_data[0]),
                .data       (cell_data[i])
            );
        end
    endgenerate

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_len_reg, out_elem_reg, out_status_reg};
    assign m_tuser  = out_has_reg;
    assign m_tlast  = out_last_reg;

endmodule

[test/tb_top.sv]
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import pss_pkg::*;

    // the one action code the block ignores
    localparam logic [2:0] ACT_UNUSED = 3'd7;

    typedef struct {
        logic [2:0]  act;
        logic [31:0] value;
        logic [5:0]  pos;
        bit          wait_idle;
    } action_item_t;

    typedef struct {
        logic [1:0]  status;
        logic [31:0] element;
        logic        has_element;
        logic        last;
        logic [5:0]  length_now;
    } seq_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [IN_DATA_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic m_tuser;
    logic m_tlast;

    positional_sequence_store_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #5 clk = ~clk;

    action_item_t pending_actions[$];
    seq_result_t  expected_results[$];
    logic [31:0]  held_values[$];

    int  gen_length = 0;
    int  mismatch_count = 0;
    int  actions_taken = 0;
    int  results_checked = 0;
    int  listing_run = 0;
    int  longest_listing = 0;
    int  full_seen = 0;
    int  range_seen = 0;
    int  empty_seen = 0;
    int  burst_left = 4;
    int  gap_left = 0;
    int  hold_left = 0;
    int  rx_cycle = 0;
    bit  long_hold_done = 1'b0;
    bit  item_taken = 1'b0;

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 50)
            $display("mismatch at %0t ns: %s", $time, msg);
    endtask

    // ---------------------------------------------------------------
    // sequence predictor
    // ---------------------------------------------------------------
    function automatic logic [1:0] place_value(input int slot, input logic [31:0] v);
        if (held_values.size() >= DEPTH)
            return ST_FULL;
        if (slot > held_values.size())
            return ST_RANGE;
        held_values.insert(slot, v);
        return ST_OK;
    endfunction

    function automatic logic [1:0] remove_value(input int slot);
        if (held_values.size() == 0)
            return ST_EMPTY;
        if (slot >= held_values.size())
            return ST_RANGE;
        held_values.delete(slot);
        return ST_OK;
    endfunction

    function automatic void push_result(input logic [1:0] st, input logic [31:0] elem,
                                        input logic has, input logic fin);
        seq_result_t r;
        r.status      = st;
        r.element     = elem;
        r.has_element = has;
        r.last        = fin;
        r.length_now  = 6'(held_values.size());
        expected_results.push_back(r);
    endfunction

    function automatic void predict_sequence(input action_item_t it);
        logic [1:0] st;
        int n;
        st = ST_OK;
        n = held_values.size();
        case (it.act)
            ACT_INS_FRONT: st = place_value(0, it.value);
            ACT_INS_END:   st = place_value(n, it.value);
            ACT_INS_POS:   st = place_value(int'(it.pos), it.value);
            ACT_DEL_FRONT: st = remove_value(0);
            ACT_DEL_END:   st = (n == 0) ? ST_EMPTY : remove_value(n - 1);
            ACT_DEL_POS:
            begin
                if (n == 0)
                    st = ST_EMPTY;
                else if (it.pos == 0)
                    st = ST_RANGE;
                else
                    st = remove_value(int'(it.pos) - 1);
            end
            ACT_LIST:
            begin
                if (n == 0)
                    push_result(ST_EMPTY, '0, 1'b0, 1'b1);
                for (int i = 0; i < n; i++)
                    push_result(ST_OK, held_values[i], 1'b1, (i == n - 1));
                return;
            end
            default: st = ST_OK;
        endcase
        push_result(st, '0, 1'b0, 1'b1);
    endfunction

    // ---------------------------------------------------------------
    // stimulus building
    // ---------------------------------------------------------------
    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0000_0000;
            3: return 32'hffff_ffff;
            default: return $urandom();
        endcase
    endfunction

    // keeps a running length so random positions mostly land inside the sequence
    function automatic void queue_action(input logic [2:0] act, input logic [31:0] v,
                                         input logic [5:0] pos, input bit wait_idle);
        action_item_t it;
        it.act = act;
        it.value = v;
        it.pos = pos;
        it.wait_idle = wait_idle;
        pending_actions.push_back(it);
        case (act)
            ACT_INS_FRONT, ACT_INS_END:
                if (gen_length < DEPTH) gen_length++;
            ACT_INS_POS:
                if (gen_length < DEPTH && int'(pos) <= gen_length) gen_length++;
            ACT_DEL_FRONT, ACT_DEL_END:
                if (gen_length > 0) gen_length--;
            ACT_DEL_POS:
                if (gen_length > 0 && pos >= 1 && int'(pos) <= gen_length) gen_length--;
            default: ;
        endcase
    endfunction

    function automatic void queue_random(input int ins_pct, input int del_pct,
                                         input bit wait_idle);
        int r;
        logic [2:0] act;
        logic [5:0] pos;
        r = $urandom_range(0, 99);
        pos = 6'($urandom_range(0, 32));
        if (r < ins_pct)
        begin
            act = 3'(ACT_INS_FRONT + $urandom_range(0, 2));
            if ($urandom_range(0, 9) < 7)
                pos = 6'($urandom_range(0, gen_length));
            else if ($urandom_range(0, 1) == 0)
                pos = 6'(gen_length);
        end
        else if (r < ins_pct + del_pct)
        begin
            act = 3'(ACT_DEL_FRONT + $urandom_range(0, 2));
            if (gen_length > 0 && $urandom_range(0, 9) < 7)
                pos = 6'($urandom_range(1, gen_length));
        end
        else if (r < 98)
            act = ACT_LIST;
        else
            act = ACT_UNUSED;
        queue_action(act, pick_value(), pos, wait_idle);
    endfunction

    // ---------------------------------------------------------------
    // input driver: bursts with random gaps
    // ---------------------------------------------------------------
    always @(negedge clk)
    begin
        logic nv;
        action_item_t it;
        nv = s_tvalid;
        if (s_tvalid && item_taken)
            nv = 1'b0;
        item_taken = 1'b0;
        if (rst_n && !nv)
        begin
            if (gap_left > 0)
                gap_left--;
            else if (pending_actions.size() > 0 &&
                     (!pending_actions[0].wait_idle || expected_results.size() == 0))
            begin
                it = pending_actions.pop_front();
                s_tdata <= {7'b0, it.pos, it.value, it.act};
                nv = 1'b1;
                burst_left--;
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, 12);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
        end
        s_tvalid <= nv;
    end

    // ---------------------------------------------------------------
    // result receiver: one long hold-off, and stall patterns in four phases of receiver cycles
    // ---------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_left > 0)
        begin
            m_tready <= 1'b0;
            hold_left--;
        end
        else if (!long_hold_done && actions_taken >= 70)
        begin
            // long hold-off while the sender keeps offering
            long_hold_done = 1'b1;
            hold_left = 150;
            m_tready <= 1'b0;
        end
        else
        begin
            rx_cycle++;
            case ((rx_cycle / 128) % 4)
                0: m_tready <= 1'b1;
                1: m_tready <= 1'($urandom_range(0, 1));
                2: m_tready <= ($urandom_range(0, 3) == 0);
                default: m_tready <= (rx_cycle % 3 == 0);
            endcase
        end
    end

    // ---------------------------------------------------------------
    // monitor: checks results, predicts at input acceptance
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        seq_result_t got;
        seq_result_t want;
        action_item_t it;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got.status      = m_tdata[1:0];
                got.element     = m_tdata[33:2];
                got.length_now  = m_tdata[39:34];
                got.has_element = m_tuser;
                got.last        = m_tlast;
                if (expected_results.size() == 0)
                    report_mismatch("result transaction with nothing expected");
                else
                begin
                    want = expected_results.pop_front();
                    results_checked++;
                    if (got.status !== want.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  got.status, want.status));
                    if (got.element !== want.element)
                        report_mismatch($sformatf("element %h, expected %h",
                                                  got.element, want.element));
                    if (got.has_element !== want.has_element)
                        report_mismatch($sformatf("has_element %b, expected %b",
                                                  got.has_element, want.has_element));
                    if (got.last !== want.last)
                        report_mismatch($sformatf("last %b, expected %b",
                                                  got.last, want.last));
                    if (got.length_now !== want.length_now)
                        report_mismatch($sformatf("length %0d, expected %0d",
                                                  got.length_now, want.length_now));
                    case (want.status)
                        ST_FULL:  full_seen++;
                        ST_RANGE: range_seen++;
                        ST_EMPTY: empty_seen++;
                        default: ;
                    endcase
                    if (want.has_element)
                    begin
                        listing_run++;
                        if (listing_run > longest_listing)
                            longest_listing = listing_run;
                    end
                    if (want.last)
                        listing_run = 0;
                end
            end
            if (s_tvalid && s_tready)
            begin
                it.act   = s_tdata[2:0];
                it.value = s_tdata[34:3];
                it.pos   = s_tdata[40:35];
                predict_sequence(it);
                actions_taken++;
                item_taken = 1'b1;
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("timeout at %0t ns, %0d results still expected", $time,
                 expected_results.size());
        $display("positional_sequence_store_unit verification failed");
        $finish;
    end

    initial
    begin
        // directed: empty cases, extremes, ordering, every action
        queue_action(ACT_LIST,      32'h0,         6'd0,  1'b0);
        queue_action(ACT_DEL_FRONT, 32'h0,         6'd0,  1'b0);
        queue_action(ACT_DEL_END,   32'h0,         6'd0,  1'b0);
        queue_action(ACT_DEL_POS,   32'h0,         6'd0,  1'b0);
        queue_action(ACT_INS_POS,   32'h1234_5678, 6'd1,  1'b0);
        queue_action(ACT_INS_POS,   32'hdead_beef, 6'd32, 1'b0);
        queue_action(ACT_INS_POS,   32'h7fff_ffff, 6'd0,  1'b0);
        queue_action(ACT_INS_FRONT, 32'h8000_0000, 6'd0,  1'b0);
        queue_action(ACT_INS_END,   32'hffff_ffff, 6'd0,  1'b0);
        queue_action(ACT_INS_END,   32'h0000_0000, 6'd0,  1'b0);
        // position equal to the length appends
        queue_action(ACT_INS_POS,   32'h5a5a_5a5a, 6'd4,  1'b0);
        queue_action(ACT_INS_POS,   32'ha5a5_a5a5, 6'd2,  1'b0);
        queue_action(ACT_INS_POS,   32'h0f0f_0f0f, 6'd7,  1'b0);
        queue_action(ACT_LIST,      32'h0,         6'd0,  1'b0);
        queue_action(ACT_DEL_POS,   32'h0,         6'd0,  1'b0);
        queue_action(ACT_DEL_POS,   32'h0,         6'd7,  1'b0);
        queue_action(ACT_DEL_POS,   32'h0,         6'd6,  1'b0);
        queue_action(ACT_DEL_POS,   32'h0,         6'd2,  1'b0);
        queue_action(ACT_DEL_FRONT, 32'h0,         6'd0,  1'b0);
        queue_action(ACT_DEL_END,   32'h0,         6'd0,  1'b0);
        queue_action(ACT_UNUSED,    32'hc3c3_3c3c, 6'd63, 1'b0);
        queue_action(ACT_LIST,      32'h0,         6'd0,  1'b0);

        // grow to full, hit the full store, list all of it
        for (int i = 0; i < 50; i++)
        begin
            if (gen_length == DEPTH && i < 45)
            begin
                queue_action(ACT_LIST, 32'h0, 6'd0, 1'b0);
                queue_action(ACT_INS_FRONT, pick_value(), 6'd0, 1'b0);
                queue_action(ACT_INS_POS, pick_value(), 6'd32, 1'b0);
                queue_action(ACT_INS_END, pick_value(), 6'd0, 1'b0);
                i = 45;
            end
            queue_random(85, 8, 1'b0);
        end
        for (int i = 0; i < 70; i++)
            queue_random(40, 40, 1'b0);
        // shrink to empty after a full drain
        for (int i = 0; i < 45; i++)
            queue_random(8, 85, (i == 0));
        for (int i = 0; i < 40; i++)
            queue_random(45, 40, (i == 0));
        queue_action(ACT_LIST, 32'h0, 6'd0, 1'b0);

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (pending_actions.size() > 0 || s_tvalid || expected_results.size() > 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        while (expected_results.size() > 0)
        begin
            void'(expected_results.pop_front());
            report_mismatch("expected result never arrived");
        end

        $display("%0d actions, %0d results checked; longest listing %0d elements",
                 actions_taken, results_checked, longest_listing);
        $display("store-full %0d, out-of-range %0d, empty %0d statuses; %0d mismatches",
                 full_seen, range_seen, empty_seen, mismatch_count);
        if (mismatch_count == 0)
            $display("positional_sequence_store_unit verification clean");
        else
            $display("positional_sequence_store_unit verification failed");
        $finish;
    end

endmodule
